// ===== sv/sps_pkg.sv =====
// Shared constants and types for the stable priority sorter.
package sps_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] rank;
    logic signed [DATA_W-1:0] payload;
  } entry_t;

  // per-cycle command to the chain
  typedef struct packed {
    logic load;   // insert new entry in rank order
    logic drain;  // shift every entry one cell toward the head
  } chain_ctrl_t;

endpackage

// ===== sv/sps_cell.sv =====
// One cell of the sorting chain: holds one entry, compares, shifts.
module sps_cell (
  input  logic                clk,
  input  sps_pkg::chain_ctrl_t ctrl,
  input  logic                occupied,
  input  sps_pkg::entry_t     new_entry,
  input  sps_pkg::entry_t     prev_entry,
  input  logic                prev_ahead,
  input  sps_pkg::entry_t     next_entry,
  output sps_pkg::entry_t     entry,
  output logic                ahead
);

  sps_pkg::entry_t entry_r;
  sps_pkg::entry_t entry_nxt;

  // new entry lands at or ahead of this cell; strict compare keeps ties stable
  assign ahead = !occupied || ($signed(entry_r.rank) > $signed(new_entry.rank));

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl.drain) begin
      entry_nxt = next_entry;
    end else if (ctrl.load && ahead && !prev_ahead) begin
      entry_nxt = new_entry;
    end else if (ctrl.load && ahead) begin
      entry_nxt = prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== sv/stable_priority_sorter.sv =====
// Top level of the stable priority sorter: cell chain plus load/drain control.
//
// Collects a batch of (payload, rank) pairs, one request per cycle while busy
// is low, into a chain of CAPACITY cells kept sorted by signed rank as each
// pair arrives. The request with in_final_item set closes the batch: busy
// rises on the next cycle and the batch streams out in ascending rank order,
// one pair per cycle on out_valid, until every stored pair is out. Pairs of
// equal rank come out in arrival order. The receiver cannot stall; every pair
// appears for exactly one cycle. Once the chain is full, further requests
// (a final one included) are dropped and out_dropped_flag is high on every
// pair of that batch. out_final marks the last pair; busy falls in the
// following cycle and loading resumes. Throughput: one request per cycle
// while loading; the drain shifts the chain one cell toward the head each
// cycle.
module stable_priority_sorter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [sps_pkg::DATA_W-1:0] in_payload,
  input  logic signed [sps_pkg::DATA_W-1:0] in_rank,
  input  logic                             in_final_item,
  output logic                             out_valid,
  output logic signed [sps_pkg::DATA_W-1:0] out_payload,
  output logic signed [sps_pkg::DATA_W-1:0] out_rank,
  output logic                             out_final,
  output logic                             out_dropped_flag
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;
  localparam logic [sps_pkg::CNT_W-1:0] FULL_CNT = sps_pkg::CNT_W'(sps_pkg::CAPACITY);
  localparam logic [sps_pkg::CNT_W-1:0] ONE_CNT  = sps_pkg::CNT_W'(1);

  logic                      state_r, state_nxt;
  logic [sps_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      overflow_r, overflow_nxt;

  logic                  accept;
  logic                  full;
  sps_pkg::chain_ctrl_t  ctrl;
  sps_pkg::entry_t       new_entry;
  sps_pkg::entry_t       cell_entry [sps_pkg::CAPACITY];
  logic                  cell_ahead [sps_pkg::CAPACITY];

  assign busy   = (state_r == ST_EMIT);
  assign accept = start && !busy;
  assign full   = (count_r == FULL_CNT);

  assign new_entry.rank    = in_rank;
  assign new_entry.payload = in_payload;

  // insert only when there is room; drain every cycle while emitting
  assign ctrl.load  = accept && !full;
  assign ctrl.drain = busy;

  // the chain: cell 0 is the head and holds the smallest rank
  for (genvar i = 0; i < sps_pkg::CAPACITY; i++) begin : g_cell
    sps_pkg::entry_t prev_e;
    sps_pkg::entry_t next_e;
    logic            prev_b;

    if (i == 0) begin : g_head
      assign prev_e = new_entry;
      assign prev_b = 1'b0;
    end else begin : g_body
      assign prev_e = cell_entry[i-1];
      assign prev_b = cell_ahead[i-1];
    end

    if (i == sps_pkg::CAPACITY - 1) begin : g_tail
      assign next_e = cell_entry[i];
    end else begin : g_mid
      assign next_e = cell_entry[i+1];
    end

    sps_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (sps_pkg::CNT_W'(i) < count_r),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_ahead (prev_b),
      .next_entry (next_e),
      .entry      (cell_entry[i]),
      .ahead      (cell_ahead[i])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            overflow_nxt = 1'b1;
          end else begin
            count_nxt = count_r + ONE_CNT;
          end
          if (in_final_item) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        count_nxt = count_r - ONE_CNT;
        if (count_r == ONE_CNT) begin
          state_nxt    = ST_LOAD;
          overflow_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // results come straight from the head cell
  assign out_valid        = busy;
  assign out_payload      = cell_entry[0].payload;
  assign out_rank         = cell_entry[0].rank;
  assign out_final        = busy && (count_r == ONE_CNT);
  assign out_dropped_flag = overflow_r;

endmodule

// ===== sv/sps_checker.sv =====
// Port-level checks for the stable priority sorter, bound to the top level.
module sps_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             in_final_item,
  input logic                             out_valid,
  input logic signed [sps_pkg::DATA_W-1:0] out_rank,
  input logic                             out_final,
  input logic                             out_dropped_flag
);

  // results appear only while requests are held off
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside busy window");

  // a closing request starts emission
  a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_final_item) |=> out_valid)
    else $error("batch close did not start emission");

  // last pair releases the block
  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final) |=> !busy)
    else $error("busy held after last pair");

  // a batch streams without gaps, sorted, with a steady drop flag
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_final) |=> (out_valid && $stable(out_dropped_flag)
      && ($signed(out_rank) >= $signed($past(out_rank)))))
    else $error("batch stream broken or out of order");

endmodule

bind stable_priority_sorter sps_checker u_sps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_final_item   (in_final_item),
  .out_valid       (out_valid),
  .out_rank        (out_rank),
  .out_final       (out_final),
  .out_dropped_flag(out_dropped_flag)
);

// ===== sim/tb_stable_priority_sorter.sv =====
// Testbench for stable_priority_sorter: batch requests against a stable-sort scoreboard.
`timescale 1ns / 1ps

module tb_stable_priority_sorter;

  localparam int unsigned CYCLE_LIMIT  = 200_000;  // far beyond the slowest correct run
  localparam int unsigned DRAIN_CYCLES = 40;       // one full drain plus margin
  localparam int unsigned ITEMS_PER_PHASE = 35;

  localparam logic signed [sps_pkg::DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [sps_pkg::DATA_W-1:0] S_MIN = 32'sh8000_0000;

  // One emitted pair as the receiver sees it.
  typedef struct packed {
    logic signed [sps_pkg::DATA_W-1:0] payload;
    logic signed [sps_pkg::DATA_W-1:0] rank;
    logic                              last_pair;
    logic                              dropped;
  } sorted_pair_t;

  // Rank patterns for random batches.
  typedef enum int {
    RANK_FULL,   // anywhere in the 32-bit range
    RANK_TIES,   // tiny range, so equal ranks are common
    RANK_EDGE    // corner values only
  } rank_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the batch store and the stable sort, and holds the
  // pairs the block still owes us in emission order.
  // --------------------------------------------------------------------------
  class sort_scoreboard;
    sps_pkg::entry_t open_batch[$];   // pairs of the batch being loaded, arrival order
    logic            batch_overflow;  // a request of this batch was dropped
    sorted_pair_t    owed_pairs[$];   // predicted results, oldest first
    int unsigned     fail_count;

    function new();
      batch_overflow = 1'b0;
      fail_count     = 0;
    endfunction

    function void report_fail(string what);
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] mismatch: %s", $time, what);
    endfunction

    // Accepted request: store it (or drop it when full); a closing request
    // sorts the batch and queues the whole batch as owed results.
    function void note_request(logic signed [sps_pkg::DATA_W-1:0] payload,
                               logic signed [sps_pkg::DATA_W-1:0] rank,
                               logic final_item);
      sps_pkg::entry_t pair;
      sps_pkg::entry_t cur;
      sorted_pair_t    owed;
      int              j;
      pair.payload = payload;
      pair.rank    = rank;
      if (open_batch.size() < sps_pkg::CAPACITY)
        open_batch.push_back(pair);
      else
        batch_overflow = 1'b1;
      if (final_item) begin
        // insertion sort, strict greater-than keeps equal ranks in arrival order
        for (int i = 1; i < open_batch.size(); i++) begin
          cur = open_batch[i];
          j   = i;
          while (j > 0 && $signed(open_batch[j-1].rank) > $signed(cur.rank)) begin
            open_batch[j] = open_batch[j-1];
            j--;
          end
          open_batch[j] = cur;
        end
        foreach (open_batch[i]) begin
          owed.payload   = open_batch[i].payload;
          owed.rank      = open_batch[i].rank;
          owed.last_pair = (i == open_batch.size() - 1);
          owed.dropped   = batch_overflow;
          owed_pairs.push_back(owed);
        end
        open_batch.delete();
        batch_overflow = 1'b0;
      end
    endfunction

    function void check_result(sorted_pair_t got);
      sorted_pair_t want;
      if (owed_pairs.size() == 0) begin
        report_fail($sformatf("unexpected pair payload=%0d rank=%0d final=%0b dropped=%0b",
                              got.payload, got.rank, got.last_pair, got.dropped));
        return;
      end
      want = owed_pairs.pop_front();
      if (got.payload !== want.payload || got.rank !== want.rank ||
          got.last_pair !== want.last_pair || got.dropped !== want.dropped)
        report_fail($sformatf({"expected payload=%0d rank=%0d final=%0b dropped=%0b, ",
                               "got payload=%0d rank=%0d final=%0b dropped=%0b"},
                              want.payload, want.rank, want.last_pair, want.dropped,
                              got.payload, got.rank, got.last_pair, got.dropped));
    endfunction

    function int unsigned pending();
      return owed_pairs.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic signed [sps_pkg::DATA_W-1:0] in_payload;
  logic signed [sps_pkg::DATA_W-1:0] in_rank;
  logic                              in_final_item;
  logic                              out_valid;
  logic signed [sps_pkg::DATA_W-1:0] out_payload;
  logic signed [sps_pkg::DATA_W-1:0] out_rank;
  logic                              out_final;
  logic                              out_dropped_flag;

  stable_priority_sorter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_payload       (in_payload),
    .in_rank          (in_rank),
    .in_final_item    (in_final_item),
    .out_valid        (out_valid),
    .out_payload      (out_payload),
    .out_rank         (out_rank),
    .out_final        (out_final),
    .out_dropped_flag (out_dropped_flag)
  );

  sort_scoreboard sb = new();

  int unsigned idle_pct;      // chance, in percent, of the sender sitting out a cycle
  int unsigned items_sent;
  int unsigned cycle_count = 0;

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge; inputs only move at
  // the falling edge, so the values seen here are settled. The result check
  // runs before the request is noted, so an emitted pair is never matched
  // against a batch closed on the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    sorted_pair_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.payload   = out_payload;
        got.rank      = out_rank;
        got.last_pair = out_final;
        got.dropped   = out_dropped_flag;
        sb.check_result(got);
      end
      if (start && !busy)
        sb.note_request(in_payload, in_rank, in_final_item);
    end
  end

  // Watchdog: a hung block ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Present one request and hold it until it is taken. busy only moves on
  // the rising edge, so its value at the falling edge tells whether the
  // coming edge accepts the request. start stays high across back-to-back
  // requests; during sender gaps it drops and the fields carry junk.
  task automatic drive_request(input logic signed [sps_pkg::DATA_W-1:0] payload,
                               input logic signed [sps_pkg::DATA_W-1:0] rank,
                               input logic final_item);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start         = 1'b0;
      in_payload    = $urandom;
      in_rank       = $urandom;
      in_final_item = $urandom_range(0, 1);
      @(negedge clk);
    end
    start         = 1'b1;
    in_payload    = payload;
    in_rank       = rank;
    in_final_item = final_item;
    while (busy) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  function automatic logic signed [sps_pkg::DATA_W-1:0] pick_rank(rank_mode_t mode);
    logic signed [sps_pkg::DATA_W-1:0] corner [6];
    corner = '{S_MIN, S_MAX, 32'sd0, -32'sd1, S_MIN + 32'sd1, S_MAX - 32'sd1};
    case (mode)
      RANK_TIES: begin
        return $signed($urandom_range(0, 6)) - 32'sd3;
      end
      RANK_EDGE: begin
        return corner[$urandom_range(0, 5)];
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // One batch of random pairs; the last request closes it.
  task automatic send_random_batch(input int unsigned size);
    rank_mode_t mode;
    mode = rank_mode_t'($urandom_range(0, 2));
    for (int unsigned i = 0; i < size; i++)
      drive_request($urandom, pick_rank(mode), i == size - 1);
  endtask

  // Batch sizes lean small, with regular full and overflowing batches.
  function automatic int unsigned pick_batch_size();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5)      return $urandom_range(1, 6);
    else if (sel == 6) return $urandom_range(7, sps_pkg::CAPACITY - 1);
    else if (sel == 7) return sps_pkg::CAPACITY;
    else               return $urandom_range(sps_pkg::CAPACITY + 1, sps_pkg::CAPACITY + 4);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_pct [4];
    int unsigned phase_start;
    phase_pct     = '{0, 49, 0, 14};
    rst_n         = 1'b0;
    start         = 1'b0;
    in_payload    = '0;
    in_rank       = '0;
    in_final_item = 1'b0;
    idle_pct      = 0;
    items_sent    = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: a batch of one pair at the field extremes.
    drive_request(S_MIN, S_MAX, 1'b1);

    // Directed: rank extremes, zero and minus one, with a tie at zero that
    // must keep its arrival order.
    drive_request(S_MAX, S_MAX, 1'b0);
    drive_request(32'sd0, S_MIN, 1'b0);
    drive_request(-32'sd1, 32'sd0, 1'b0);
    drive_request(S_MIN, -32'sd1, 1'b0);
    drive_request(32'sd1, 32'sd0, 1'b1);

    // Directed: fill the store, then the closing request is dropped but
    // still starts the drain with the overflow flag on every pair.
    for (int i = 0; i < sps_pkg::CAPACITY + 1; i++)
      drive_request(i, $signed(i % 3), i == sps_pkg::CAPACITY);

    // Random batches, in phases that each set a sender idle rate.
    foreach (phase_pct[p]) begin
      idle_pct    = phase_pct[p];
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE)
        send_random_batch(pick_batch_size());
    end

    @(negedge clk);
    start = 1'b0;

    // Let the last drain finish, then watch for stray pairs.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0 && sb.open_batch.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sps_pkg.sv
sv/sps_cell.sv
sv/stable_priority_sorter.sv
sv/sps_checker.sv
sim/tb_stable_priority_sorter.sv
